// File: hw/rtl/tcs_pkg.sv
// Shared types and constants for the text cell store.
// No dependencies; every other file but tcs_ram imports it.
package tcs_pkg;

    typedef enum logic [2:0] {
        OP_WRITE    = 3'd0,
        OP_MARK     = 3'd1,
        OP_REGION   = 3'd2,
        OP_MARK_ALL = 3'd3,
        OP_COMMIT   = 3'd4,
        OP_QCELL    = 3'd5,
        OP_QLINE    = 3'd6,
        OP_CLEAR    = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_INIT, ST_IDLE, ST_READ, ST_SWEEP, ST_COMMIT, ST_FIN
    } t_state;

    localparam logic [1:0] CFG_ROWS        = 2'd0;
    localparam logic [1:0] CFG_COLS        = 2'd1;
    localparam logic [1:0] CFG_BLANK_ATTR  = 2'd2;
    localparam logic [1:0] CFG_BLANK_COLOR = 2'd3;

    localparam int          CELL_W   = 45;
    localparam logic [20:0] BLANK_CP = 21'h000020;
    localparam logic [6:0]  NO_ROW   = 7'h7F;

    // decoded word passed from the front end to the executor
    typedef struct packed {
        t_op         op;
        logic [5:0]  row;
        logic [6:0]  col;
        logic [5:0]  erow;      // clamped region end
        logic [6:0]  ecol;
        logic [6:0]  rows_m1;   // size in use minus one
        logic [7:0]  cols_m1;
        logic        row_ok;
        logic        col_ok;
        logic        region_ok; // start row within clamped end row
        logic        span_ok;   // start col within clamped end col
        logic [20:0] cp;
        logic [7:0]  attr;
        logic [7:0]  fg;
        logic [7:0]  bg;
    } t_cmd;

endpackage

// File: hw/rtl/text_cell_store_dirty_tracking_core.sv
// Top level of the text cell store: configuration registers, front end, executor.
// Depends on tcs_pkg, tcs_front, tcs_back (and tcs_ram below it).
//
// Character-cell store with damage tracking; one result word per input word.
// After reset a clearing pass blanks the cell RAM and input is stalled meanwhile.
// Cell writes and cell queries pass through dequeue with RAM read, compare/write
// and result; mark cell, query line and out-of-range operations through dequeue
// and result. Mark region, mark all and clear visit one cell per cycle through
// the one address shared by the cell and dirty RAMs; clear also blanks each cell.
// Commit sweeps the whole dirty RAM. A two-word queue lets input be taken while
// the executor works.
module text_cell_store_dirty_tracking_core import tcs_pkg::*; #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_op,
    input  logic [5:0]  i_row,
    input  logic [6:0]  i_col,
    input  logic [5:0]  i_end_row,
    input  logic [6:0]  i_end_col,
    input  logic [20:0] i_codepoint,
    input  logic [7:0]  i_attr,
    input  logic [7:0]  i_fg,
    input  logic [7:0]  i_bg,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_changed,
    output logic        o_cell_flag,
    output logic        o_line_flag,
    output logic        o_needs_update,
    output logic        o_full_redraw,
    output logic [6:0]  o_first_dirty,
    output logic [6:0]  o_last_dirty,
    output logic [20:0] o_codepoint_out,
    output logic [7:0]  o_attr_out,
    output logic [7:0]  o_fg_out,
    output logic [7:0]  o_bg_out
);
    logic [6:0] r_rows;
    logic [7:0] r_cols, r_blank_attr, r_blank_color;
    logic       w_cmd_valid, w_pop, w_busy;
    t_cmd       w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows        <= 7'd64;
            r_cols        <= 8'd128;
            r_blank_attr  <= 8'd0;
            r_blank_color <= 8'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROWS:        r_rows <= i_cfg_wdata[6:0];
                CFG_COLS:        r_cols <= i_cfg_wdata;
                CFG_BLANK_ATTR:  r_blank_attr <= i_cfg_wdata;
                CFG_BLANK_COLOR: r_blank_color <= i_cfg_wdata;
            endcase
        end
    end

    tcs_front #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_op(i_op), .i_row(i_row), .i_col(i_col),
        .i_end_row(i_end_row), .i_end_col(i_end_col),
        .i_codepoint(i_codepoint), .i_attr(i_attr), .i_fg(i_fg), .i_bg(i_bg),
        .i_rows_cfg(r_rows), .i_cols_cfg(r_cols), .i_busy(w_busy),
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_pop(w_pop)
    );

    tcs_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd), .o_pop(w_pop), .o_busy(w_busy),
        .i_blank_attr(r_blank_attr), .i_blank_color(r_blank_color),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_changed(o_changed), .o_cell_flag(o_cell_flag),
        .o_line_flag(o_line_flag), .o_needs_update(o_needs_update),
        .o_full_redraw(o_full_redraw), .o_first_dirty(o_first_dirty),
        .o_last_dirty(o_last_dirty), .o_codepoint_out(o_codepoint_out),
        .o_attr_out(o_attr_out), .o_fg_out(o_fg_out), .o_bg_out(o_bg_out)
    );

    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> o_in_stall) else $error("input taken during clearing pass");
    a_pop_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_cmd_valid) else $error("dequeue from empty queue");
    a_range_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_first_dirty == NO_ROW) |-> (o_last_dirty == NO_ROW))
        else $error("dirty range half empty");
    a_redraw_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_full_redraw |-> o_needs_update)
        else $error("redraw without update");
endmodule

// File: hw/rtl/tcs_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module tcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/tcs_front.sv
// Front end: takes input words, clamps against the size in use, queues them.
// Depends on tcs_pkg.
module tcs_front import tcs_pkg::*; #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_op,
    input  logic [5:0]  i_row,
    input  logic [6:0]  i_col,
    input  logic [5:0]  i_end_row,
    input  logic [6:0]  i_end_col,
    input  logic [20:0] i_codepoint,
    input  logic [7:0]  i_attr,
    input  logic [7:0]  i_fg,
    input  logic [7:0]  i_bg,
    input  logic [6:0]  i_rows_cfg,
    input  logic [7:0]  i_cols_cfg,
    input  logic        i_busy,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_pop
);
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;
    int         er, ec, erow, ecol;

    always_comb begin
        er = (i_rows_cfg == 7'd0) ? 1 :
             (32'(i_rows_cfg) > MAX_ROWS) ? MAX_ROWS : 32'(i_rows_cfg);
        ec = (i_cols_cfg == 8'd0) ? 1 :
             (32'(i_cols_cfg) > MAX_COLS) ? MAX_COLS : 32'(i_cols_cfg);
        erow = (32'(i_end_row) >= er) ? er - 1 : 32'(i_end_row);
        ecol = (32'(i_end_col) >= ec) ? ec - 1 : 32'(i_end_col);
        w_cmd.op        = t_op'(i_op);
        w_cmd.row       = i_row;
        w_cmd.col       = i_col;
        w_cmd.erow      = 6'(erow);
        w_cmd.ecol      = 7'(ecol);
        w_cmd.rows_m1   = 7'(er - 1);
        w_cmd.cols_m1   = 8'(ec - 1);
        w_cmd.row_ok    = 32'(i_row) < er;
        w_cmd.col_ok    = 32'(i_col) < ec;
        w_cmd.region_ok = 32'(i_row) <= erow;
        w_cmd.span_ok   = 32'(i_col) <= ecol;
        w_cmd.cp        = i_codepoint;
        w_cmd.attr      = i_attr;
        w_cmd.fg        = i_fg;
        w_cmd.bg        = i_bg;
    end

    assign o_in_stall  = (r_cnt == 2'd2) || i_busy;
    assign w_push      = i_in_valid && !o_in_stall;
    assign o_cmd_valid = r_cnt != 2'd0;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end
endmodule

// File: hw/rtl/tcs_back.sv
// Executor: cell RAMs, line dirty bits, dirty range and the result register.
// Depends on tcs_pkg and tcs_ram.
module tcs_back import tcs_pkg::*; #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_busy,
    input  logic [7:0]  i_blank_attr,
    input  logic [7:0]  i_blank_color,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_changed,
    output logic        o_cell_flag,
    output logic        o_line_flag,
    output logic        o_needs_update,
    output logic        o_full_redraw,
    output logic [6:0]  o_first_dirty,
    output logic [6:0]  o_last_dirty,
    output logic [20:0] o_codepoint_out,
    output logic [7:0]  o_attr_out,
    output logic [7:0]  o_fg_out,
    output logic [7:0]  o_bg_out
);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int RESET_LAST = ((MAX_ROWS < 64) ? MAX_ROWS : 64) - 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    logic [MAX_ROWS-1:0] r_lines, n_lines;
    logic [6:0] r_first, n_first, r_last, n_last;
    logic r_valid, n_valid, r_redraw, n_redraw;
    logic [AW-1:0] r_lin, n_lin;
    logic [6:0] r_r, n_r, r_r_end, n_r_end;
    logic [7:0] r_c, n_c, r_c_start, n_c_start, r_c_end, n_c_end;
    logic r_blank, n_blank;
    logic r_changed, n_changed, r_qd, n_qd;
    logic [CELL_W-1:0] r_qdata, n_qdata;
    logic r_out_valid, n_out_valid;
    logic r_o_changed, n_o_changed, r_o_cd, n_o_cd, r_o_ld, n_o_ld;
    logic r_o_nu, n_o_nu, r_o_fr, n_o_fr;
    logic [6:0] r_o_first, n_o_first, r_o_last, n_o_last;
    logic [CELL_W-1:0] r_o_data, n_o_data;

    logic [AW-1:0]     w_addr;
    logic              w_data_we, w_dirty_we, w_dirty_wd, w_dirty_rd;
    logic [CELL_W-1:0] w_data_wd, w_data_rd;

    function automatic logic [AW-1:0] cell_at(input logic [6:0] r, input logic [7:0] c);
        return AW'(r) * AW'(MAX_COLS) + AW'(c);
    endfunction

    tcs_ram #(.WIDTH(CELL_W), .DEPTH(DEPTH)) u_data (
        .i_clk(i_clk), .i_we(w_data_we), .i_addr(w_addr),
        .i_wdata(w_data_wd), .o_rdata(w_data_rd)
    );
    tcs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_dirty (
        .i_clk(i_clk), .i_we(w_dirty_we), .i_addr(w_addr),
        .i_wdata(w_dirty_wd), .o_rdata(w_dirty_rd)
    );

    always_comb begin
        n_state = r_state;   n_cmd = r_cmd;       n_lines = r_lines;
        n_first = r_first;   n_last = r_last;     n_valid = r_valid;
        n_redraw = r_redraw; n_lin = r_lin;       n_r = r_r;
        n_r_end = r_r_end;   n_c = r_c;           n_c_start = r_c_start;
        n_c_end = r_c_end;   n_blank = r_blank;   n_changed = r_changed;
        n_qd = r_qd;         n_qdata = r_qdata;   n_out_valid = r_out_valid;
        n_o_changed = r_o_changed; n_o_cd = r_o_cd; n_o_ld = r_o_ld;
        n_o_nu = r_o_nu;     n_o_fr = r_o_fr;     n_o_first = r_o_first;
        n_o_last = r_o_last; n_o_data = r_o_data;
        o_pop = 1'b0;
        w_addr = r_lin;
        w_data_we = 1'b0;
        w_data_wd = {BLANK_CP, i_blank_attr, i_blank_color, i_blank_color};
        w_dirty_we = 1'b0;
        w_dirty_wd = 1'b1;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_INIT: begin
                w_data_we  = 1'b1;
                w_data_wd  = {BLANK_CP, 24'd0};
                w_dirty_we = 1'b1;
                n_lin = r_lin + AW'(1);
                if (r_lin == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                w_addr = cell_at({1'b0, i_cmd.row}, {1'b0, i_cmd.col});
                if (i_cmd_valid && (!r_out_valid || !i_out_stall)) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    n_changed = 1'b0;
                    n_qd = 1'b0;
                    n_qdata = '0;
                    n_state = ST_FIN;
                    unique case (i_cmd.op)
                        OP_WRITE, OP_QCELL: begin
                            if (i_cmd.row_ok && i_cmd.col_ok) begin
                                n_state = ST_READ;
                            end
                        end
                        OP_MARK: begin
                            if (i_cmd.row_ok) begin
                                n_lines[RW'(i_cmd.row)] = 1'b1;
                                if (!r_valid || {1'b0, i_cmd.row} < r_first) begin
                                    n_first = {1'b0, i_cmd.row};
                                end
                                if (!r_valid || {1'b0, i_cmd.row} > r_last) begin
                                    n_last = {1'b0, i_cmd.row};
                                end
                                n_valid = 1'b1;
                                w_dirty_we = i_cmd.col_ok;
                            end
                        end
                        OP_REGION: begin
                            if (i_cmd.region_ok) begin
                                for (int k = 0; k < MAX_ROWS; k++) begin
                                    if (k >= 32'(i_cmd.row) && k <= 32'(i_cmd.erow)) begin
                                        n_lines[k] = 1'b1;
                                    end
                                end
                                if (!r_valid || {1'b0, i_cmd.row} < r_first) begin
                                    n_first = {1'b0, i_cmd.row};
                                end
                                if (!r_valid || {1'b0, i_cmd.erow} > r_last) begin
                                    n_last = {1'b0, i_cmd.erow};
                                end
                                n_valid = 1'b1;
                                if (i_cmd.span_ok) begin
                                    n_r = {1'b0, i_cmd.row};
                                    n_r_end = {1'b0, i_cmd.erow};
                                    n_c = {1'b0, i_cmd.col};
                                    n_c_start = {1'b0, i_cmd.col};
                                    n_c_end = {1'b0, i_cmd.ecol};
                                    n_blank = 1'b0;
                                    n_state = ST_SWEEP;
                                end
                            end
                        end
                        OP_MARK_ALL, OP_CLEAR: begin
                            for (int k = 0; k < MAX_ROWS; k++) begin
                                if (k <= 32'(i_cmd.rows_m1)) begin
                                    n_lines[k] = 1'b1;
                                end
                            end
                            n_redraw = 1'b1;
                            n_first = 7'd0;
                            n_last = i_cmd.rows_m1;
                            n_valid = 1'b1;
                            n_r = 7'd0;
                            n_r_end = i_cmd.rows_m1;
                            n_c = 8'd0;
                            n_c_start = 8'd0;
                            n_c_end = i_cmd.cols_m1;
                            n_blank = i_cmd.op == OP_CLEAR;
                            n_state = ST_SWEEP;
                        end
                        OP_COMMIT: begin
                            n_lines = '0;
                            n_valid = 1'b0;
                            n_first = 7'd0;
                            n_last = 7'd0;
                            n_redraw = 1'b0;
                            n_lin = '0;
                            n_state = ST_COMMIT;
                        end
                        OP_QLINE: begin
                            n_state = ST_FIN;
                        end
                    endcase
                end
            end
            ST_READ: begin
                w_addr = cell_at({1'b0, r_cmd.row}, {1'b0, r_cmd.col});
                w_data_wd = {r_cmd.cp, r_cmd.attr, r_cmd.fg, r_cmd.bg};
                if (r_cmd.op == OP_WRITE) begin
                    if (w_data_rd != w_data_wd) begin
                        w_data_we = 1'b1;
                        w_dirty_we = 1'b1;
                        n_changed = 1'b1;
                        n_lines[RW'(r_cmd.row)] = 1'b1;
                        if (!r_valid || {1'b0, r_cmd.row} < r_first) begin
                            n_first = {1'b0, r_cmd.row};
                        end
                        if (!r_valid || {1'b0, r_cmd.row} > r_last) begin
                            n_last = {1'b0, r_cmd.row};
                        end
                        n_valid = 1'b1;
                    end
                end else begin
                    n_qd = w_dirty_rd;
                    n_qdata = w_data_rd;
                end
                n_state = ST_FIN;
            end
            ST_SWEEP: begin
                w_addr = cell_at(r_r, r_c);
                w_dirty_we = 1'b1;
                w_data_we = r_blank;
                if (r_c == r_c_end) begin
                    n_c = r_c_start;
                    n_r = r_r + 7'd1;
                    if (r_r == r_r_end) begin
                        n_state = ST_FIN;
                    end
                end else begin
                    n_c = r_c + 8'd1;
                end
            end
            ST_COMMIT: begin
                w_dirty_we = 1'b1;
                w_dirty_wd = 1'b0;
                n_lin = r_lin + AW'(1);
                if (r_lin == LAST_ADDR) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_out_valid = 1'b1;
                n_o_changed = r_changed;
                n_o_cd = r_qd;
                n_o_ld = (r_cmd.op == OP_QLINE) && r_cmd.row_ok && r_lines[RW'(r_cmd.row)];
                n_o_nu = r_redraw || r_valid;
                n_o_fr = r_redraw;
                n_o_first = r_valid ? r_first : NO_ROW;
                n_o_last = r_valid ? r_last : NO_ROW;
                n_o_data = r_qdata;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_lin       <= '0;
            r_lines     <= '1;
            r_first     <= 7'd0;
            r_last      <= 7'(RESET_LAST);
            r_valid     <= 1'b1;
            r_redraw    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lin       <= n_lin;
            r_lines     <= n_lines;
            r_first     <= n_first;
            r_last      <= n_last;
            r_valid     <= n_valid;
            r_redraw    <= n_redraw;
            r_out_valid <= n_out_valid;
        end
        r_cmd <= n_cmd;       r_r <= n_r;             r_r_end <= n_r_end;
        r_c <= n_c;           r_c_start <= n_c_start; r_c_end <= n_c_end;
        r_blank <= n_blank;   r_changed <= n_changed; r_qd <= n_qd;
        r_qdata <= n_qdata;   r_o_changed <= n_o_changed;
        r_o_cd <= n_o_cd;     r_o_ld <= n_o_ld;       r_o_nu <= n_o_nu;
        r_o_fr <= n_o_fr;     r_o_first <= n_o_first; r_o_last <= n_o_last;
        r_o_data <= n_o_data;
    end

    assign o_busy          = r_state == ST_INIT;
    assign o_out_valid     = r_out_valid;
    assign o_changed       = r_o_changed;
    assign o_cell_flag     = r_o_cd;
    assign o_line_flag     = r_o_ld;
    assign o_needs_update  = r_o_nu;
    assign o_full_redraw   = r_o_fr;
    assign o_first_dirty   = r_o_first;
    assign o_last_dirty    = r_o_last;
    assign o_codepoint_out = r_o_data[44:24];
    assign o_attr_out      = r_o_data[23:16];
    assign o_fg_out        = r_o_data[15:8];
    assign o_bg_out        = r_o_data[7:0];
endmodule

// File: tb/sv/tb_text_cell_store_dirty_tracking_core.sv
// Self-checking bench for text_cell_store_dirty_tracking_core: directed table, then random words.
// Depends on tcs_pkg and the core RTL; results are checked against an in-bench cell store model.
module tb_text_cell_store_dirty_tracking_core;
    import tcs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NROWS = 64;
    localparam int NCOLS = 128;
    localparam int NCELL = NROWS * NCOLS;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        t_op         op;
        logic [5:0]  row;
        logic [6:0]  col;
        logic [5:0]  erow;
        logic [6:0]  ecol;
        logic [20:0] cp;
        logic [7:0]  attr;
        logic [7:0]  fg;
        logic [7:0]  bg;
    } cmd_word_t;

    typedef struct packed {
        logic        changed;
        logic        cell_flag;
        logic        line_flag;
        logic        needs_update;
        logic        full_redraw;
        logic [6:0]  first;
        logic [6:0]  last;
        logic [20:0] cp;
        logic [7:0]  attr;
        logic [7:0]  fg;
        logic [7:0]  bg;
    } status_word_t;

    typedef struct packed {
        cmd_word_t    cmd;
        logic         fixed;
        status_word_t want;
    } dir_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_ROWS;
    logic [7:0]  i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_op = OP_QLINE;
    logic [5:0]  i_row = '0;
    logic [6:0]  i_col = '0;
    logic [5:0]  i_end_row = '0;
    logic [6:0]  i_end_col = '0;
    logic [20:0] i_codepoint = '0;
    logic [7:0]  i_attr = '0;
    logic [7:0]  i_fg = '0;
    logic [7:0]  i_bg = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_changed, o_cell_flag, o_line_flag, o_needs_update, o_full_redraw;
    logic [6:0]  o_first_dirty, o_last_dirty;
    logic [20:0] o_codepoint_out;
    logic [7:0]  o_attr_out, o_fg_out, o_bg_out;

    text_cell_store_dirty_tracking_core dut (.*);

    always #1 i_clk = ~i_clk;

    // shadow copy of the store
    logic [20:0] sh_cp[NCELL];
    logic [7:0]  sh_attr[NCELL];
    logic [7:0]  sh_fg[NCELL];
    logic [7:0]  sh_bg[NCELL];
    logic        sh_dirty[NCELL];
    logic        sh_line[NROWS];
    int          sh_first, sh_last;
    logic        sh_range, sh_redraw;
    logic [6:0]  reg_rows = 7'd64;
    logic [7:0]  reg_cols = 8'd128;
    logic [7:0]  reg_battr = '0;
    logic [7:0]  reg_bcolor = '0;

    status_word_t pending_q[$];
    int  mismatches = 0;
    int  cycles = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_req = 0;
    int  hold_left = 0;

    function automatic int rows_eff();
        return (reg_rows == 0) ? 1 : (reg_rows > NROWS) ? NROWS : int'(reg_rows);
    endfunction

    function automatic int cols_eff();
        return (reg_cols == 0) ? 1 : (reg_cols > NCOLS) ? NCOLS : int'(reg_cols);
    endfunction

    function automatic void widen(int lo, int hi);
        if (!sh_range || lo < sh_first) sh_first = lo;
        if (!sh_range || hi > sh_last) sh_last = hi;
        sh_range = 1'b1;
    endfunction

    function automatic void flag_everything();
        int nr, nc;
        nr = rows_eff();
        nc = cols_eff();
        sh_redraw = 1'b1;
        for (int r = 0; r < nr; r++) begin
            sh_line[r] = 1'b1;
            for (int c = 0; c < nc; c++) sh_dirty[r*NCOLS+c] = 1'b1;
        end
        sh_first = 0;
        sh_last = nr - 1;
        sh_range = 1'b1;
    endfunction

    function automatic void blank_rect(int nr, int nc);
        int k;
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++) begin
                k = r*NCOLS + c;
                sh_cp[k] = BLANK_CP;
                sh_attr[k] = reg_battr;
                sh_fg[k] = reg_bcolor;
                sh_bg[k] = reg_bcolor;
                sh_dirty[k] = 1'b1;
            end
    endfunction

    // advance the shadow store by one word and return its status word
    function automatic status_word_t apply_word(cmd_word_t w);
        status_word_t s;
        int nr, nc, k, er, ec;
        logic rok, cok;
        s = '0;
        nr = rows_eff();
        nc = cols_eff();
        rok = w.row < nr;
        cok = w.col < nc;
        k = w.row*NCOLS + w.col;
        case (w.op)
            OP_WRITE: begin
                if (rok && cok && (sh_cp[k] != w.cp || sh_attr[k] != w.attr ||
                        sh_fg[k] != w.fg || sh_bg[k] != w.bg)) begin
                    sh_cp[k] = w.cp;
                    sh_attr[k] = w.attr;
                    sh_fg[k] = w.fg;
                    sh_bg[k] = w.bg;
                    sh_dirty[k] = 1'b1;
                    sh_line[w.row] = 1'b1;
                    widen(w.row, w.row);
                    s.changed = 1'b1;
                end
            end
            OP_MARK: begin
                if (rok) begin
                    sh_line[w.row] = 1'b1;
                    widen(w.row, w.row);
                    if (cok) sh_dirty[k] = 1'b1;
                end
            end
            OP_REGION: begin
                er = (w.erow >= nr) ? nr - 1 : int'(w.erow);
                ec = (w.ecol >= nc) ? nc - 1 : int'(w.ecol);
                if (w.row <= er) begin
                    for (int r = w.row; r <= er; r++) begin
                        sh_line[r] = 1'b1;
                        for (int c = w.col; c <= ec; c++) sh_dirty[r*NCOLS+c] = 1'b1;
                    end
                    widen(w.row, er);
                end
            end
            OP_MARK_ALL: flag_everything();
            OP_COMMIT: begin
                for (int j = 0; j < NCELL; j++) sh_dirty[j] = 1'b0;
                for (int r = 0; r < NROWS; r++) sh_line[r] = 1'b0;
                sh_range = 1'b0;
                sh_first = 0;
                sh_last = 0;
                sh_redraw = 1'b0;
            end
            OP_QCELL: begin
                if (rok && cok) begin
                    s.cell_flag = sh_dirty[k];
                    s.cp = sh_cp[k];
                    s.attr = sh_attr[k];
                    s.fg = sh_fg[k];
                    s.bg = sh_bg[k];
                end
            end
            OP_QLINE: if (rok) s.line_flag = sh_line[w.row];
            default: begin
                blank_rect(nr, nc);
                flag_everything();
            end
        endcase
        s.needs_update = sh_redraw || sh_range;
        s.full_redraw = sh_redraw;
        s.first = sh_range ? 7'(sh_first) : NO_ROW;
        s.last = sh_range ? 7'(sh_last) : NO_ROW;
        return s;
    endfunction

    task automatic send_word(cmd_word_t w, logic fixed, status_word_t want);
        status_word_t s;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= w.op;
        i_row <= w.row;
        i_col <= w.col;
        i_end_row <= w.erow;
        i_end_col <= w.ecol;
        i_codepoint <= w.cp;
        i_attr <= w.attr;
        i_fg <= w.fg;
        i_bg <= w.bg;
        do @(posedge i_clk); while (o_in_stall);
        s = apply_word(w);
        pending_q.push_back(fixed ? want : s);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // leaves the write enable high; the caller drops it after the last write
    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_ROWS:       reg_rows = val[6:0];
            CFG_COLS:       reg_cols = val;
            CFG_BLANK_ATTR: reg_battr = val;
            default:        reg_bcolor = val;
        endcase
    endtask

    function automatic cmd_word_t random_word(logic [20:0] last_cp, logic [7:0] last_attr,
                                              logic [5:0] last_row, logic [6:0] last_col);
        cmd_word_t w;
        int pick, nr, nc;
        nr = rows_eff();
        nc = cols_eff();
        w.cp = ($urandom_range(3) == 0) ? 21'h1FFFFF : 21'($urandom);
        w.attr = 8'($urandom);
        w.fg = 8'($urandom);
        w.bg = 8'($urandom);
        if ($urandom_range(4) != 0) begin
            w.row = 6'($urandom_range(0, nr - 1));
            w.col = 7'($urandom_range(0, nc - 1));
        end else begin
            w.row = 6'($urandom);
            w.col = 7'($urandom);
        end
        w.erow = w.row + 6'($urandom_range(0, 3));
        w.ecol = w.col + 7'($urandom_range(0, 7));
        if (nr * nc <= 512 && $urandom_range(9) == 0) begin
            w.erow = 6'($urandom);
            w.ecol = 7'($urandom);
        end
        pick = $urandom_range(99);
        if (pick < 35) w.op = OP_WRITE;
        else if (pick < 45) w.op = OP_MARK;
        else if (pick < 57) w.op = OP_REGION;
        else if (pick < 60) w.op = (nr * nc <= 512) ? OP_MARK_ALL : OP_MARK;
        else if (pick < 62) w.op = OP_COMMIT;
        else if (pick < 87) w.op = OP_QCELL;
        else if (pick < 97) w.op = OP_QLINE;
        else w.op = (nr * nc <= 512) ? OP_CLEAR : OP_QLINE;
        // now and then rewrite the previous cell with its code point and attribute and colours 5A/A5
        if (w.op == OP_WRITE && $urandom_range(5) == 0) begin
            w.row = last_row;
            w.col = last_col;
            w.cp = last_cp;
            w.attr = last_attr;
            w.fg = 8'h5A;
            w.bg = 8'hA5;
        end
        if (w.op == OP_WRITE && w.fg == 8'h5A && w.bg == 8'hA5) w.attr = last_attr;
        return w;
    endfunction

    // receiver stall, with an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        status_word_t got, want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_text_cell_store_dirty_tracking_core: done, errors");
            $finish;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_changed, o_cell_flag, o_line_flag, o_needs_update, o_full_redraw,
                    o_first_dirty, o_last_dirty, o_codepoint_out, o_attr_out, o_fg_out,
                    o_bg_out};
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %p", got);
            end else begin
                want = pending_q.pop_front();
                if (got.changed != want.changed || got.cell_flag != want.cell_flag ||
                    got.line_flag != want.line_flag ||
                    got.needs_update != want.needs_update ||
                    got.full_redraw != want.full_redraw || got.first != want.first ||
                    got.last != want.last || got.cp != want.cp || got.attr != want.attr ||
                    got.fg != want.fg || got.bg != want.bg) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at cycle %0d\n  exp %p\n  got %p", cycles, want, got);
                end
            end
        end
    end

    initial begin
        dir_row_t     dir_tab[$];
        status_word_t z, t;
        cmd_word_t    w;
        logic [7:0]   ph_rows[6] = '{8'd0, 8'd8, 8'd127, 8'd5, 8'd1, 8'd64};
        logic [7:0]   ph_cols[6] = '{8'd0, 8'd16, 8'd255, 8'd7, 8'd128, 8'd1};
        int           ph_send[6] = '{0, 58, 0, 14, 0, 58};
        int           ph_recv[6] = '{0, 0, 58, 14, 0, 0};
        logic [20:0]  last_cp = 0;
        logic [7:0]   last_attr = 0;
        logic [5:0]   last_row = 0;
        logic [6:0]   last_col = 0;

        for (int j = 0; j < NCELL; j++) begin
            sh_cp[j] = BLANK_CP;
            sh_attr[j] = 0;
            sh_fg[j] = 0;
            sh_bg[j] = 0;
            sh_dirty[j] = 1'b1;
        end
        for (int r = 0; r < NROWS; r++) sh_line[r] = 1'b1;
        sh_first = 0;
        sh_last = NROWS - 1;
        sh_range = 1'b1;
        sh_redraw = 1'b1;

        z = '0;
        // after reset: blank, dirty, whole screen pending
        t = z; t.cell_flag = 1; t.needs_update = 1; t.full_redraw = 1;
        t.first = 0; t.last = 63; t.cp = BLANK_CP;
        dir_tab.push_back('{'{OP_QCELL, 6'd0, 7'd0, 6'd0, 7'd0, 21'd0, 8'd0, 8'd0, 8'd0}, 1, t});
        t = z; t.first = NO_ROW; t.last = NO_ROW;
        dir_tab.push_back('{'{OP_COMMIT, 6'd0, 7'd0, 6'd0, 7'd0, 21'd0, 8'd0, 8'd0, 8'd0}, 1, t});
        dir_tab.push_back('{'{OP_QLINE, 6'd63, 7'd0, 6'd0, 7'd0, 21'd0, 8'd0, 8'd0, 8'd0}, 1, t});
        t = z; t.changed = 1; t.needs_update = 1; t.first = 63; t.last = 63;
        dir_tab.push_back('{'{OP_WRITE, 6'd63, 7'd127, 6'd0, 7'd0, 21'h1FFFFF, 8'hFF, 8'hFF,
                              8'hFF}, 1, t});
        t.changed = 0;
        dir_tab.push_back('{'{OP_WRITE, 6'd63, 7'd127, 6'd0, 7'd0, 21'h1FFFFF, 8'hFF, 8'hFF,
                              8'hFF}, 1, t});
        t.cell_flag = 1; t.cp = 21'h1FFFFF; t.attr = 8'hFF; t.fg = 8'hFF; t.bg = 8'hFF;
        dir_tab.push_back('{'{OP_QCELL, 6'd63, 7'd127, 6'd0, 7'd0, 21'd0, 8'd0, 8'd0, 8'd0},
                            1, t});
        dir_tab.push_back('{'{OP_WRITE, 6'd0, 7'd0, 6'd0, 7'd0, 21'd0, 8'd0, 8'd0, 8'd0}, 0, z});
        dir_tab.push_back('{'{OP_QCELL, 6'd0, 7'd0, 6'd0, 7'd0, 21'd0, 8'd0, 8'd0, 8'd0}, 0, z});
        dir_tab.push_back('{'{OP_QLINE, 6'd1, 7'd0, 6'd0, 7'd0, 21'd0, 8'd0, 8'd0, 8'd0}, 0, z});
        dir_tab.push_back('{'{OP_MARK, 6'd10, 7'd5, 6'd0, 7'd0, 21'd0, 8'd0, 8'd0, 8'd0}, 0, z});
        dir_tab.push_back('{'{OP_QCELL, 6'd10, 7'd5, 6'd0, 7'd0, 21'd0, 8'd0, 8'd0, 8'd0}, 0, z});
        // end at the last row and column of the grid
        dir_tab.push_back('{'{OP_REGION, 6'd60, 7'd120, 6'd63, 7'd127, 21'd0, 8'd0, 8'd0, 8'd0},
                            0, z});
        // start row past end row: no effect
        dir_tab.push_back('{'{OP_REGION, 6'd20, 7'd0, 6'd10, 7'd3, 21'd0, 8'd0, 8'd0, 8'd0},
                            0, z});
        // start column past end column: lines only
        dir_tab.push_back('{'{OP_REGION, 6'd2, 7'd100, 6'd3, 7'd50, 21'd0, 8'd0, 8'd0, 8'd0},
                            0, z});
        dir_tab.push_back('{'{OP_QLINE, 6'd3, 7'd0, 6'd0, 7'd0, 21'd0, 8'd0, 8'd0, 8'd0}, 0, z});
        dir_tab.push_back('{'{OP_COMMIT, 6'd0, 7'd0, 6'd0, 7'd0, 21'd0, 8'd0, 8'd0, 8'd0}, 0, z});
        dir_tab.push_back('{'{OP_MARK_ALL, 6'd0, 7'd0, 6'd0, 7'd0, 21'd0, 8'd0, 8'd0, 8'd0},
                            0, z});
        dir_tab.push_back('{'{OP_QCELL, 6'd63, 7'd127, 6'd0, 7'd0, 21'd0, 8'd0, 8'd0, 8'd0},
                            0, z});
        dir_tab.push_back('{'{OP_CLEAR, 6'd0, 7'd0, 6'd0, 7'd0, 21'd0, 8'd0, 8'd0, 8'd0}, 0, z});
        dir_tab.push_back('{'{OP_QCELL, 6'd63, 7'd127, 6'd0, 7'd0, 21'd0, 8'd0, 8'd0, 8'd0},
                            0, z});
        dir_tab.push_back('{'{OP_COMMIT, 6'd0, 7'd0, 6'd0, 7'd0, 21'd0, 8'd0, 8'd0, 8'd0}, 0, z});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[n]) send_word(dir_tab[n].cmd, dir_tab[n].fixed, dir_tab[n].want);
        drain();

        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_ROWS, ph_rows[p]);
            write_reg(CFG_COLS, ph_cols[p]);
            write_reg(CFG_BLANK_ATTR, (p % 2) ? 8'hFF : 8'($urandom));
            write_reg(CFG_BLANK_COLOR, (p % 3 == 1) ? 8'hFF : 8'($urandom));
            i_cfg_we <= 1'b0;
            send_idle_pct = ph_send[p];
            recv_stall_pct = ph_recv[p];
            // long receiver hold-off fills the block while words keep coming
            if (p == 4) hold_req = 400;
            for (int n = 0; n < 125; n++) begin
                if (n == 60) drain();
                w = random_word(last_cp, last_attr, last_row, last_col);
                if (w.op == OP_WRITE) begin
                    last_cp = w.cp;
                    last_attr = w.attr;
                    last_row = w.row;
                    last_col = w.col;
                    if ($urandom_range(5) == 0) begin
                        w.fg = 8'h5A;
                        w.bg = 8'hA5;
                    end
                end
                send_word(w, 1'b0, z);
            end
            drain();
        end

        recv_stall_pct = 0;
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && pending_q.size() == 0)
            $display("tb_text_cell_store_dirty_tracking_core: done, clean");
        else
            $display("tb_text_cell_store_dirty_tracking_core: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/tcs_pkg.sv
hw/rtl/tcs_ram.sv
hw/rtl/tcs_front.sv
hw/rtl/tcs_back.sv
hw/rtl/text_cell_store_dirty_tracking_core.sv
tb/sv/tb_text_cell_store_dirty_tracking_core.sv
